// ===== sv/gcsmm_pkg.sv =====
// Shared types and constants for the grouped count, sum, minimum and maximum core.
`default_nettype none
package gcsmm_pkg;

    // Table geometry.
    localparam int NUM_ROWS = 64;
    localparam int NUM_COLS = 64;
    localparam int CELLS    = NUM_ROWS * NUM_COLS;
    localparam int CELL_AW  = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;
    localparam logic signed [31:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    // Request codes.
    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [31:0] sample_value;
        logic               batch_end;
    } t_in_word;

    typedef struct packed {
        logic               status;
        logic [23:0]        count_out;
        logic signed [63:0] sum_out;
        logic signed [31:0] min_out;
        logic signed [31:0] max_out;
        logic               batch_end_out;
    } t_out_word;

    // One entry of the statistics memory.
    typedef struct packed {
        logic [23:0]        count;
        logic signed [63:0] sum;
        logic signed [31:0] min;
        logic signed [31:0] max;
    } t_cell;

    localparam t_cell CELL_INIT = '{
        count: 24'd0,
        sum:   64'sd0,
        min:   SAMPLE_MAX,
        max:   SAMPLE_MIN
    };

endpackage
`default_nettype wire

// ===== sv/gcsmm_cell_upd.sv =====
// Update datapath for one cell: saturating count and sum, running minimum and maximum.
`default_nettype none
module gcsmm_cell_upd (
    input  var gcsmm_pkg::t_cell        i_cell,
    input  var logic signed [31:0]      i_sample,
    output var gcsmm_pkg::t_cell        o_cell
);
    import gcsmm_pkg::*;

    logic signed [64:0] w_sum_wide;

    // The sum overflows exactly when the two top bits of the widened result differ.
    assign w_sum_wide = {i_cell.sum[63], i_cell.sum} + 65'(i_sample);

    always_comb begin
        o_cell.count = (i_cell.count != COUNT_MAX) ? i_cell.count + 24'd1 : i_cell.count;
        if (w_sum_wide[64] != w_sum_wide[63]) begin
            o_cell.sum = w_sum_wide[64] ? SUM_MIN : SUM_MAX;
        end else begin
            o_cell.sum = w_sum_wide[63:0];
        end
        o_cell.min = (i_sample < i_cell.min) ? i_sample : i_cell.min;
        o_cell.max = (i_sample > i_cell.max) ? i_sample : i_cell.max;
    end

endmodule
`default_nettype wire

// ===== sv/grouped_count_sum_min_max_core.sv =====
// Top level: per-cell count, sum, minimum and maximum kept in one synchronous memory.
// A word accepted is registered with its cell's read data; its result then enters the output register.
// No new word is taken until the read then modify-and-write of the previous word's cell is done.
// A full output register stalls the write-back step until the result is taken.
// Reset: i_rst_n is synchronous and active low; afterwards a clearing pass writes the empty-cell
// values to all 4096 cells, one after another, and no input word is accepted until it ends.
`default_nettype none
module grouped_count_sum_min_max_core (
    input  var logic                   i_clk,
    input  var logic                   i_rst_n,
    input  var logic                   i_in_valid,
    output var logic                   o_in_ready,
    input  var gcsmm_pkg::t_in_word    i_in_data,
    output var logic                   o_out_valid,
    input  var logic                   i_out_ready,
    output var gcsmm_pkg::t_out_word   o_out_data
);
    import gcsmm_pkg::*;

    // Controller states.
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // The statistics of every cell live in a single memory; it has no reset of its
    // own and is initialized by the clearing pass instead.
    t_cell r_mem [CELLS];

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CELL_AW-1:0] r_clr_addr;
    logic [CELL_AW-1:0] n_clr_addr;

    // Request held while its cell is read and updated.
    t_in_word           r_req;
    logic [CELL_AW-1:0] r_req_addr;
    logic               r_req_range_err;
    t_cell              r_rd_data;

    // Output register.
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_word          r_out_data;
    t_out_word          n_out_data;

    logic               w_accept;
    logic               w_exec_go;
    logic               w_range_err;
    logic [CELL_AW-1:0] w_addr;
    t_cell              w_upd_cell;
    t_cell              w_result_cell;
    logic               w_wr_en;
    logic [CELL_AW-1:0] w_wr_addr;
    t_cell              w_wr_data;

    // Input side: a word is taken only when the previous one has been written back.
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Range check and flat cell address, row-major.
    assign w_range_err = (32'(i_in_data.row_index) >= NUM_ROWS) ||
                         (32'(i_in_data.col_index) >= NUM_COLS);
    assign w_addr = CELL_AW'(32'(i_in_data.row_index) * NUM_COLS + 32'(i_in_data.col_index));

    gcsmm_cell_upd u_cell_upd (
        .i_cell   (r_rd_data),
        .i_sample (r_req.sample_value),
        .o_cell   (w_upd_cell)
    );

    // The write-back step may proceed once the output register is free or being emptied.
    assign w_exec_go = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    assign w_result_cell = (r_req.req_type == REQ_ACCUM) ? w_upd_cell : r_rd_data;

    // One write port, shared by the clearing pass and the write-back of accumulate requests.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_clr_addr;
        w_wr_data = CELL_INIT;
        if (r_state == ST_CLEAR) begin
            w_wr_en = 1'b1;
        end else if (w_exec_go && !r_req_range_err && (r_req.req_type == REQ_ACCUM)) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_req_addr;
            w_wr_data = w_upd_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_accept) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    // Request registers carry payload only.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req           <= i_in_data;
            r_req_addr      <= w_addr;
            r_req_range_err <= w_range_err;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + CELL_AW'(1);
                if (r_clr_addr == CELL_AW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_exec_go) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_data.batch_end_out = r_req.batch_end;
                    if (r_req_range_err) begin
                        // Out-of-range index: report it with all statistics zero.
                        n_out_data.status    = STATUS_RANGE;
                        n_out_data.count_out = '0;
                        n_out_data.sum_out   = '0;
                        n_out_data.min_out   = '0;
                        n_out_data.max_out   = '0;
                    end else begin
                        n_out_data.status    = STATUS_OK;
                        n_out_data.count_out = w_result_cell.count;
                        n_out_data.sum_out   = w_result_cell.sum;
                        n_out_data.min_out   = w_result_cell.min;
                        n_out_data.max_out   = w_result_cell.max;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire
